// File: src/scmf_pkg.sv
// Package for the SLIP CRC-16 message framer: item types, codes and the CRC step.
`default_nettype none
package scmf_pkg;

  // Item kinds
  localparam logic [1:0] KIND_BEGIN   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // SLIP special bytes
  localparam logic [7:0] BYTE_DELIM   = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  // Reflected CRC-16
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Own address after reset
  localparam logic [7:0] SRC_RESET = 8'h11;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] dest_address;
    logic [7:0] control_field;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic [7:0] link_dest;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // One raw byte queued for the back end; frame_end bytes bypass escaping
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] link_dest;
    logic       run_last;
    logic       frame_end;
  } entry_t;

  // CRC over one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = data[i] ^ c[0];
      c  = (c >> 1) ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/slip_crc16_message_framer.sv
// Top level of the SLIP CRC-16 message framer.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | in_item_t (kind, addresses, bytes)
//   out_    | output    | out_valid / out_stall | out_item_t (line byte, flags)
//   cfg_    | input     | cfg_we                | cfg_wdata (source address)
//
// Front, while the queue has room: begin queues source, control (one CRC byte per cycle,
// dest first); end queues CRC lo, hi, delimiter (one queued byte per cycle). Back: 1 line
// byte per cycle unless stalled, escaped bytes as ESC then code. Payload rate is set by the
// output register: 1 item per cycle unless stalled. Bytes pass item_r, queue, output reg.
// Reset is synchronous; it empties the queue and output and restores CRC 0xFFFF,
// destination 0 and source address 0x11. Output stalls back up through the queue.
`default_nettype none
module slip_crc16_message_framer
  import scmf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  entry_t push_entry;
  entry_t head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_not_empty;

  scmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  scmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  scmf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

// File: src/scmf_front.sv
// Front end: accepts items, runs the CRC and queues raw frame bytes.
`default_nettype none
module scmf_front
  import scmf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic     q_full,
  output logic          q_push,
  output entry_t        q_entry
);

  in_item_t    item_r;
  logic        item_v_r;
  logic [1:0]  step_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  held_dest_r;
  logic [7:0]  src_addr_r;
  logic        want_push;
  logic        last_step;
  logic        advance;
  logic        in_accept;

  // Per-step work for the item held
  always_comb begin
    want_push         = 1'b0;
    last_step         = 1'b0;
    crc_nxt           = crc_r;
    q_entry.raw_byte  = 8'h00;
    q_entry.link_dest = held_dest_r;
    q_entry.run_last  = 1'b0;
    q_entry.frame_end = 1'b0;
    case (item_r.kind)
      KIND_BEGIN: begin
        case (step_r)
          2'd0: begin
            want_push        = 1'b1;
            q_entry.raw_byte = src_addr_r;
            crc_nxt          = crc16_byte(CRC_INIT, item_r.dest_address);
          end
          2'd1: begin
            want_push        = 1'b1;
            q_entry.raw_byte = item_r.control_field;
            q_entry.run_last = 1'b1;
            crc_nxt          = crc16_byte(crc_r, src_addr_r);
          end
          default: begin
            crc_nxt   = crc16_byte(crc_r, item_r.control_field);
            last_step = 1'b1;
          end
        endcase
      end
      KIND_PAYLOAD: begin
        want_push        = 1'b1;
        q_entry.raw_byte = item_r.payload_byte;
        q_entry.run_last = 1'b1;
        crc_nxt          = crc16_byte(crc_r, item_r.payload_byte);
        last_step        = 1'b1;
      end
      KIND_END: begin
        want_push = 1'b1;
        case (step_r)
          2'd0: q_entry.raw_byte = crc_r[7:0];
          2'd1: q_entry.raw_byte = crc_r[15:8];
          default: begin
            q_entry.raw_byte  = BYTE_DELIM;
            q_entry.run_last  = 1'b1;
            q_entry.frame_end = 1'b1;
            last_step         = 1'b1;
          end
        endcase
      end
      default: last_step = 1'b1;  // unknown kind: dropped
    endcase
  end

  assign advance   = item_v_r && (!want_push || !q_full);
  assign q_push    = item_v_r && want_push && !q_full;
  assign in_stall  = item_v_r && !(advance && last_step);
  assign in_accept = in_valid && !in_stall;

  // Item sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      step_r   <= 2'd0;
    end else if (in_accept) begin
      item_v_r <= 1'b1;
      step_r   <= 2'd0;
    end else if (advance && last_step) begin
      item_v_r <= 1'b0;
    end else if (advance) begin
      step_r <= step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_item;
    end
  end

  // Frame state and the source address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      held_dest_r <= 8'h00;
      src_addr_r  <= SRC_RESET;
    end else begin
      if (advance) begin
        crc_r <= crc_nxt;
      end
      if (in_accept && in_item.kind == KIND_BEGIN) begin
        held_dest_r <= in_item.dest_address;
      end
      if (cfg_we) begin
        src_addr_r <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/scmf_queue.sv
// Short queue of raw frame bytes between front and back ends.
`default_nettype none
module scmf_queue
  import scmf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output entry_t      head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: src/scmf_back.sv
// Back end: SLIP-escapes queued bytes into the registered output channel.
`default_nettype none
module scmf_back
  import scmf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_not_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_item
);

  logic      out_valid_r;
  out_item_t out_r;
  out_item_t out_nxt;
  logic      second_r;
  logic      needs_esc;
  logic      can_load;
  logic      load;

  assign needs_esc = !q_head.frame_end &&
                     (q_head.raw_byte inside {BYTE_DELIM, BYTE_ESC});
  assign can_load  = !out_valid_r || !out_stall;
  assign load      = can_load && q_not_empty;
  assign q_pop     = load && (second_r || !needs_esc);

  // Pick the next line byte
  always_comb begin
    out_nxt.link_dest = q_head.link_dest;
    out_nxt.frame_end = 1'b0;
    if (second_r) begin
      out_nxt.line_byte = (q_head.raw_byte == BYTE_DELIM) ? BYTE_ESC_END : BYTE_ESC_ESC;
      out_nxt.run_last  = q_head.run_last;
    end else if (needs_esc) begin
      out_nxt.line_byte = BYTE_ESC;
      out_nxt.run_last  = 1'b0;
    end else begin
      out_nxt.line_byte = q_head.raw_byte;
      out_nxt.run_last  = q_head.run_last;
      out_nxt.frame_end = q_head.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= q_not_empty;
      if (q_not_empty) begin
        second_r <= !second_r && needs_esc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the SLIP CRC-16 message framer.
`timescale 1ns / 1ps
module tb;
  import scmf_pkg::*;

  // Kind code that the framer ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 12;
  localparam int END_CYCLES     = 20;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 260;
  localparam int WATCHDOG_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  // Shadow state of the framer
  logic [15:0] crc_acc;
  logic [7:0]  frame_dest;
  logic [7:0]  own_addr;

  // Line bytes still to come, oldest first
  out_item_t pending_bytes[$];
  out_item_t pend [0:4];
  int        pend_n;

  // Pacing controls; the sink and hold flags are shared with the receiver process
  bit send_pace_on = 1'b1;
  bit sink_pace_on = 1'b1;
  bit hold_req     = 1'b0;
  bit hold_active  = 1'b0;

  int fail_count      = 0;
  int items_sent      = 0;
  int frames_sent     = 0;
  int bytes_checked   = 0;
  int cfg_writes      = 0;
  int holds_done      = 0;
  int idle_cycles     = 0;

  slip_crc16_message_framer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Random byte with a strong lean toward the SLIP special codes
  function automatic logic [7:0] spec_byte();
    case ($urandom_range(0, 11))
      0: return BYTE_DELIM;
      1: return BYTE_ESC;
      2: return BYTE_ESC_END;
      3: return BYTE_ESC_ESC;
      4: return 8'h00;
      5: return 8'hFF;
      default: return rand_byte();
    endcase
  endfunction

  // Reflected CRC step: fold the byte into the low bits, then shift out eight times
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Payload byte that steers the next CRC byte to a given value
  function automatic logic [7:0] steer_crc(input logic [7:0] want, input bit high_half);
    logic [15:0] c;
    for (int v = 0; v < 256; v++) begin
      c = crc_fold(crc_acc, v[7:0]);
      if ((high_half ? c[15:8] : c[7:0]) == want) return v[7:0];
    end
    return 8'h00;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] k, input logic [7:0] d,
                                         input logic [7:0] c, input logic [7:0] p);
    in_item_t it;
    it.kind          = k;
    it.dest_address  = d;
    it.control_field = c;
    it.payload_byte  = p;
    return it;
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic put_line(input logic [7:0] b, input logic fe);
    pend[pend_n].line_byte = b;
    pend[pend_n].link_dest = frame_dest;
    pend[pend_n].run_last  = 1'b0;
    pend[pend_n].frame_end = fe;
    pend_n++;
  endtask

  task automatic put_escaped(input logic [7:0] b);
    if (b == BYTE_DELIM) begin
      put_line(BYTE_ESC, 1'b0);
      put_line(BYTE_ESC_END, 1'b0);
    end else if (b == BYTE_ESC) begin
      put_line(BYTE_ESC, 1'b0);
      put_line(BYTE_ESC_ESC, 1'b0);
    end else begin
      put_line(b, 1'b0);
    end
  endtask

  // Line bytes caused by one accepted item
  task automatic encode_item(input in_item_t it);
    pend_n = 0;
    case (it.kind)
      KIND_BEGIN: begin
        frame_dest = it.dest_address;
        crc_acc    = crc_fold(CRC_INIT, it.dest_address);
        crc_acc    = crc_fold(crc_acc, own_addr);
        crc_acc    = crc_fold(crc_acc, it.control_field);
        put_escaped(own_addr);
        put_escaped(it.control_field);
      end
      KIND_PAYLOAD: begin
        crc_acc = crc_fold(crc_acc, it.payload_byte);
        put_escaped(it.payload_byte);
      end
      KIND_END: begin
        put_escaped(crc_acc[7:0]);
        put_escaped(crc_acc[15:8]);
        put_line(BYTE_DELIM, 1'b1);
      end
      default: ;
    endcase
    if (pend_n > 0) begin
      pend[pend_n - 1].run_last = 1'b1;
      for (int i = 0; i < pend_n; i++) pending_bytes.push_back(pend[i]);
    end
  endtask

  // ---------------------------------------------------------------- driving

  // Offer one item, wait for it to be taken; valid stays high afterwards
  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    encode_item(it);
    if (it.kind != KIND_UNUSED) items_sent++;
    if (it.kind == KIND_END) frames_sent++;
  endtask

  task automatic send_begin(input logic [7:0] d, input logic [7:0] c);
    send_item(make_item(KIND_BEGIN, d, c, rand_byte()));
  endtask

  task automatic send_payload(input logic [7:0] p);
    send_item(make_item(KIND_PAYLOAD, rand_byte(), rand_byte(), p));
  endtask

  task automatic send_end();
    send_item(make_item(KIND_END, rand_byte(), rand_byte(), rand_byte()));
  endtask

  // Drop valid, let every expected byte come out, then let the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_source(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    own_addr = v;
    cfg_we   <= 1'b0;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  // Payload and end straight after reset, then more after the end
  task automatic test_before_first_begin();
    send_payload(8'h5A);
    send_end();
    send_payload(rand_byte());
    send_end();
  endtask

  // Escaping of source, control and payload bytes
  task automatic test_escape_bytes();
    write_source(BYTE_DELIM);
    send_begin(8'hFF, BYTE_ESC);
    send_payload(BYTE_DELIM);
    send_payload(BYTE_ESC);
    send_payload(BYTE_ESC_END);
    send_payload(BYTE_ESC_ESC);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_end();
    write_source(BYTE_ESC);
    send_begin(8'h00, BYTE_DELIM);
    send_end();
  endtask

  // CRC bytes that themselves need escaping
  task automatic test_crc_escape();
    send_begin(rand_byte(), rand_byte());
    send_payload(steer_crc(BYTE_DELIM, 1'b0));
    send_end();
    send_begin(rand_byte(), rand_byte());
    send_payload(steer_crc(BYTE_ESC, 1'b1));
    send_end();
  endtask

  // Unknown kind inside a frame leaves the state alone
  task automatic test_ignored_kind();
    send_begin(rand_byte(), rand_byte());
    send_item(make_item(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte()));
    send_payload(rand_byte());
    send_item(make_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF));
    send_end();
  endtask

  // Source address extremes, each with a short frame
  task automatic test_source_address();
    logic [7:0] vals [0:3];
    vals = '{8'h00, 8'hFF, rand_byte(), SRC_RESET};
    foreach (vals[i]) begin
      write_source(vals[i]);
      send_begin(rand_byte(), rand_byte());
      send_end();
    end
  endtask

  // Receiver holds off for a long stretch while a long frame keeps coming
  task automatic test_backpressure();
    bit saved;
    drain();
    saved        = send_pace_on;
    send_pace_on = 1'b0;
    hold_req     = 1'b1;
    wait (hold_active);
    send_begin(rand_byte(), spec_byte());
    repeat (24) send_payload(spec_byte());
    send_end();
    send_pace_on = saved;
    holds_done++;
  endtask

  // Mostly well-formed frames, some noise and broken frames
  task automatic test_random_traffic();
    int start, pick, n_pay;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_pace_on = !send_pace_on;
      else if (pick < 10) sink_pace_on = !sink_pace_on;
      if ($urandom_range(0, 49) == 0) write_source(spec_byte());
      if (pick < 80) begin
        n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        send_begin(spec_byte(), spec_byte());
        repeat (n_pay) send_payload(spec_byte());
        send_end();
      end else if (pick < 90) begin
        send_item(make_item(2'($urandom_range(0, 3)), spec_byte(), spec_byte(),
                            spec_byte()));
      end else begin
        // frame cut short, or an end on its own
        if ($urandom_range(0, 1)) begin
          send_begin(spec_byte(), spec_byte());
          repeat ($urandom_range(0, 3)) send_payload(spec_byte());
        end else begin
          send_end();
        end
      end
    end
    send_pace_on = 1'b1;
    sink_pace_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stall pattern, with a long hold on request
  initial begin : sink_pacing
    int run_len, hold_len;
    forever begin
      if (hold_req) begin
        out_stall   <= 1'b1;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
        out_stall   <= 1'b0;
        @(posedge clk);
      end else begin
        run_len   = $urandom_range(1, 6);
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        hold_len = sink_pace_on ? pick_gap() : 0;
        if (hold_len > 0) begin
          out_stall <= 1'b1;
          repeat (hold_len) @(posedge clk);
        end
      end
    end
  end

  // Compare each line byte taken with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected line byte %02h", out_item.line_byte);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.line_byte !== want.line_byte) begin
          $error("line_byte: expected %02h, got %02h", want.line_byte, out_item.line_byte);
          fail_count++;
        end
        if (out_item.link_dest !== want.link_dest) begin
          $error("link_dest: expected %02h, got %02h", want.link_dest, out_item.link_dest);
          fail_count++;
        end
        if (out_item.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
          fail_count++;
        end
        if (out_item.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_item.frame_end);
          fail_count++;
        end
        bytes_checked++;
      end
    end
  end

  // Ends the run when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 8'h00;
    crc_acc    = CRC_INIT;
    frame_dest = 8'h00;
    own_addr   = SRC_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_first_begin();
    test_escape_bytes();
    test_crc_escape();
    test_ignored_kind();
    test_source_address();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d closed frames), %0d line bytes checked",
             items_sent, frames_sent, bytes_checked);
    $display("source address written %0d times, long receiver hold %0d time(s)",
             cfg_writes, holds_done);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
